>>> design/erm_pkg.sv
// Shared types and constants for the extent remapping table.
`default_nettype none
package erm_pkg;

  // Default number of extents the table can hold.
  localparam int unsigned ERM_CAPACITY = 256;

  // Operation codes carried by in_op.
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_XLATE = 3'd1;
  localparam logic [2:0] OP_REWND = 3'd2;
  localparam logic [2:0] OP_NEXT  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // Status codes.
  localparam logic STS_OK      = 1'b0;
  localparam logic STS_DROPPED = 1'b1;

  // One stored extent.
  typedef struct packed {
    logic [31:0] old_start;
    logic [31:0] new_start;
    logic [31:0] length;
  } ext_t;

endpackage
`default_nettype wire

>>> design/extent_remap_table.sv
// Extent remapping table: top level with its sequencer and the extent memory.
// A word is taken when start is high and busy is low; the result word appears
// for exactly one cycle with out_valid and cannot be held off by the receiver.
// Rewind, clear, unused codes, an add to an empty table and a next entry past
// the end give their result straight from dispatch; other adds pass through
// the append check and other next entries through the read wait. Translate
// runs a binary search with one read and one compare per probe, ending in
// the search state on a miss, all paced by the one read port of the memory.
// A translate after out-of-order adds first runs a stable insertion sort over
// that same port, taking each entry as a key and moving larger entries up
// one place at a time. There is no clearing pass after reset.
`default_nettype none
module extent_remap_table #(
  parameter int unsigned CAPACITY = erm_pkg::ERM_CAPACITY
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_op,
  input  wire logic [31:0] in_old_number,
  input  wire logic [31:0] in_new_number,
  output logic             out_valid,
  output logic             out_status,
  output logic             out_found,
  output logic [31:0]      out_mapped_number,
  output logic [31:0]      out_entry_start_old,
  output logic [31:0]      out_entry_start_new,
  output logic [31:0]      out_entry_length
);
  import erm_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_ADD_CHK = 4'd2;
  localparam logic [3:0] S_SRT_I   = 4'd3;
  localparam logic [3:0] S_SRT_KEY = 4'd4;
  localparam logic [3:0] S_SRT_RD  = 4'd5;
  localparam logic [3:0] S_SRT_CMP = 4'd6;
  localparam logic [3:0] S_SRC     = 4'd7;
  localparam logic [3:0] S_SRC_CMP = 4'd8;
  localparam logic [3:0] S_NXT_W   = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic          sorted_r, sorted_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [31:0]   old_r, old_nxt;
  logic [31:0]   new_r, new_nxt;
  logic [CW-1:0] idx_r, idx_nxt;    // sort outer index
  logic [CW-1:0] pos_r, pos_nxt;    // sort hole position
  ext_t          key_r, key_nxt;    // sort key being inserted
  logic [CW-1:0] lo_r, lo_nxt;      // search lower bound
  logic [CW-1:0] hp_r, hp_nxt;      // search upper bound, exclusive
  logic [CW-1:0] mid_r, mid_nxt;

  logic          valid_r, valid_nxt;
  logic          status_r, status_nxt;
  logic          found_r, found_nxt;
  logic [31:0]   mapped_r, mapped_nxt;
  ext_t          entry_r, entry_nxt;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  ext_t          ram_wdata, ram_rdata;

  logic [31:0]   end_old, end_new, probe_end;
  logic [CW-1:0] span, mid_calc;

  erm_ram #(
    .WIDTH ($bits(ext_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared arithmetic on the word just read and on the search bounds.
  assign end_old   = ram_rdata.old_start + ram_rdata.length;
  assign end_new   = ram_rdata.new_start + ram_rdata.length;
  assign probe_end = end_old;
  assign span      = hp_r - CW'(1) - lo_r;
  assign mid_calc  = lo_r + (span >> 1);

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    sorted_nxt = sorted_r;
    op_nxt     = op_r;
    old_nxt    = old_r;
    new_nxt    = new_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    key_nxt    = key_r;
    lo_nxt     = lo_r;
    hp_nxt     = hp_r;
    mid_nxt    = mid_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    found_nxt  = found_r;
    mapped_nxt = mapped_r;
    entry_nxt  = entry_r;
    ram_we     = 1'b0;
    ram_waddr  = count_r[IW-1:0];
    ram_wdata  = '{old_start: old_r, new_start: new_r, length: 32'd1};
    ram_re     = 1'b0;
    ram_raddr  = count_r[IW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_op;
          old_nxt    = in_old_number;
          new_nxt    = in_new_number;
          status_nxt = STS_OK;
          found_nxt  = 1'b0;
          mapped_nxt = '0;
          entry_nxt  = '0;
          state_nxt  = S_DISP;
        end
      end

      S_DISP: begin
        state_nxt = S_IDLE;
        valid_nxt = 1'b1;
        unique case (op_r)
          OP_ADD: begin
            if (count_r != '0) begin
              ram_re    = 1'b1;
              ram_raddr = IW'(count_r - CW'(1));
              valid_nxt = 1'b0;
              state_nxt = S_ADD_CHK;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_XLATE: begin
            valid_nxt = 1'b0;
            lo_nxt    = '0;
            hp_nxt    = count_r;
            idx_nxt   = CW'(1);
            state_nxt = sorted_r ? S_SRC : S_SRT_I;
          end
          OP_REWND: cursor_nxt = '0;
          OP_NEXT: begin
            if (cursor_r < count_r) begin
              ram_re    = 1'b1;
              ram_raddr = cursor_r[IW-1:0];
              valid_nxt = 1'b0;
              state_nxt = S_NXT_W;
            end
          end
          OP_CLEAR: begin
            count_nxt  = '0;
            cursor_nxt = '0;
            sorted_nxt = 1'b1;
          end
          default: ;
        endcase
      end

      // Lengthen the last extent, append a new one, or drop the word.
      S_ADD_CHK: begin
        state_nxt = S_IDLE;
        valid_nxt = 1'b1;
        if (end_old == old_r && end_new == new_r) begin
          ram_we           = 1'b1;
          ram_waddr        = IW'(count_r - CW'(1));
          ram_wdata        = ram_rdata;
          ram_wdata.length = ram_rdata.length + 32'd1;
        end else if (count_r >= CW'(CAPACITY)) begin
          status_nxt = STS_DROPPED;
        end else begin
          if (end_old > old_r) begin
            sorted_nxt = 1'b0;
          end
          ram_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end

      // Stable insertion sort by old start.
      S_SRT_I: begin
        if (idx_r >= count_r) begin
          sorted_nxt = 1'b1;
          state_nxt  = S_SRC;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_r[IW-1:0];
          state_nxt = S_SRT_KEY;
        end
      end

      S_SRT_KEY: begin
        key_nxt   = ram_rdata;
        pos_nxt   = idx_r;
        state_nxt = S_SRT_RD;
      end

      S_SRT_RD: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r[IW-1:0];
          ram_wdata = key_r;
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_SRT_I;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = IW'(pos_r - CW'(1));
          state_nxt = S_SRT_CMP;
        end
      end

      S_SRT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[IW-1:0];
        if (ram_rdata.old_start > key_r.old_start) begin
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r - CW'(1);
          state_nxt = S_SRT_RD;
        end else begin
          ram_wdata = key_r;
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_SRT_I;
        end
      end

      // Binary search, one probe per pass through the search and compare states.
      S_SRC: begin
        if (lo_r < hp_r) begin
          ram_re    = 1'b1;
          ram_raddr = mid_calc[IW-1:0];
          mid_nxt   = mid_calc;
          state_nxt = S_SRC_CMP;
        end else begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_SRC_CMP: begin
        if (old_r >= ram_rdata.old_start && old_r < probe_end) begin
          found_nxt  = 1'b1;
          mapped_nxt = ram_rdata.new_start + (old_r - ram_rdata.old_start);
          valid_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end else if (old_r < ram_rdata.old_start) begin
          hp_nxt    = mid_r;
          state_nxt = S_SRC;
        end else begin
          lo_nxt    = mid_r + CW'(1);
          state_nxt = S_SRC;
        end
      end

      S_NXT_W: begin
        entry_nxt  = ram_rdata;
        cursor_nxt = cursor_r + CW'(1);
        valid_nxt  = 1'b1;
        state_nxt  = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      cursor_r <= '0;
      sorted_r <= 1'b1;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      sorted_r <= sorted_nxt;
      valid_r  <= valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    old_r    <= old_nxt;
    new_r    <= new_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    lo_r     <= lo_nxt;
    hp_r     <= hp_nxt;
    mid_r    <= mid_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    mapped_r <= mapped_nxt;
    entry_r  <= entry_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = valid_r;
  assign out_status          = status_r;
  assign out_found           = found_r;
  assign out_mapped_number   = mapped_r;
  assign out_entry_start_old = entry_r.old_start;
  assign out_entry_start_new = entry_r.new_start;
  assign out_entry_length    = entry_r.length;

endmodule
`default_nettype wire

>>> design/erm_ram.sv
// Generic single write port, single read port RAM with a registered read.
`default_nettype none
module erm_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/erm_checker.sv
// Port-level checks for the extent remapping table, bound to the top level.
`default_nettype none
module erm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic        out_status,
  input wire logic        out_found,
  input wire logic [31:0] out_mapped_number,
  input wire logic [31:0] out_entry_length
);

  // Every accepted word keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

  // Finishing a word always shows its result.
  a_done_word: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("busy fell without a result word");

  // A dropped add carries no translation.
  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (!out_found && out_entry_length == 32'd0))
    else $error("dropped add carried other fields");

  // A miss reports a zero mapped number.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_mapped_number == 32'd0))
    else $error("miss with non-zero mapped number");

endmodule

bind extent_remap_table erm_checker u_erm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_found         (out_found),
  .out_mapped_number (out_mapped_number),
  .out_entry_length  (out_entry_length)
);
`default_nettype wire
